// ===== src/hmbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hmbd_pkg
// Shared types, address constants and the I/O register lookup for the
// handheld memory bus decoder.
// ----------------------------------------------------------------------------
package hmbd_pkg;

	// Default sizes of the stores
	localparam int VIDEO_RAM_DEPTH_DEF = 8192;
	localparam int WORK_RAM_DEPTH_DEF  = 8192;
	localparam int SPRITE_ENTRIES_DEF  = 40;
	localparam int HIGH_RAM_DEPTH_DEF  = 127;

	// Bus access codes
	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// Special register addresses
	localparam logic [15:0] ADDR_JOYPAD = 16'hFF00;
	localparam logic [15:0] ADDR_DIV    = 16'hFF04;
	localparam logic [15:0] ADDR_STAT   = 16'hFF41;
	localparam logic [15:0] ADDR_DMA    = 16'hFF46;
	localparam logic [15:0] ADDR_IE     = 16'hFFFF;

	// Status register: upper five bits writable, low three read-only
	localparam logic [7:0] STAT_WMASK = 8'hF8;
	localparam logic [7:0] DIV_CLEAR  = 8'h00;

	localparam int IO_COUNT    = 21;
	localparam int IO_IDX_W    = 5;
	// Window offset width for video / work RAM and echo
	localparam int OFF_W       = 13;
	// Index into the small store (sprite + high RAM + I/O), wide enough for
	// the largest legal configuration
	localparam int SMALL_IDX_W = 9;
	// Fraction bits of the reciprocal used for the window modulo
	localparam int RECIP_SHIFT = 28;

	typedef struct packed {
		logic       command;
		logic [15:0] address;
		logic [7:0] write_data;
		logic [7:0] joypad_lines;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       mapped;
	} rsp_t;

	typedef struct packed {
		logic                   hit;
		logic                   big;     // video / work RAM store
		logic                   video;
		logic [OFF_W-1:0]       offset;
		logic [SMALL_IDX_W-1:0] small_idx;
		logic                   joypad;
		logic                   div;
		logic                   stat;
	} dec_t;

	typedef struct packed {
		logic                hit;
		logic [IO_IDX_W-1:0] idx;
	} io_t;

	function automatic io_t io_lookup(logic [15:0] a);
		io_t r;
		r.hit = 1'b1;
		unique case (a)
			ADDR_JOYPAD: r.idx = 5'd0;
			16'hFF01:    r.idx = 5'd1;
			16'hFF02:    r.idx = 5'd2;
			ADDR_DIV:    r.idx = 5'd3;
			16'hFF05:    r.idx = 5'd4;
			16'hFF06:    r.idx = 5'd5;
			16'hFF07:    r.idx = 5'd6;
			16'hFF0F:    r.idx = 5'd7;
			16'hFF40:    r.idx = 5'd8;
			ADDR_STAT:   r.idx = 5'd9;
			16'hFF42:    r.idx = 5'd10;
			16'hFF43:    r.idx = 5'd11;
			16'hFF44:    r.idx = 5'd12;
			16'hFF45:    r.idx = 5'd13;
			ADDR_DMA:    r.idx = 5'd14;
			16'hFF47:    r.idx = 5'd15;
			16'hFF48:    r.idx = 5'd16;
			16'hFF49:    r.idx = 5'd17;
			16'hFF4A:    r.idx = 5'd18;
			16'hFF4B:    r.idx = 5'd19;
			ADDR_IE:     r.idx = 5'd20;
			default: begin
				r.hit = 1'b0;
				r.idx = 5'd0;
			end
		endcase
		return r;
	endfunction

endpackage

// ===== src/hmbd_decode.sv =====
// ----------------------------------------------------------------------------
// hmbd_decode
// Address map decode: selects the store, the window offset and the index
// into the small store, and flags the registers with special behavior.
// ----------------------------------------------------------------------------
module hmbd_decode #(
	parameter int SPRITE_ENTRIES = hmbd_pkg::SPRITE_ENTRIES_DEF,
	parameter int HIGH_RAM_DEPTH = hmbd_pkg::HIGH_RAM_DEPTH_DEF
) (
	input  logic [15:0]   address,
	output hmbd_pkg::dec_t dec
);

	localparam int SPR_BYTES = 4 * SPRITE_ENTRIES;
	localparam int IDX_W     = hmbd_pkg::SMALL_IDX_W;

	logic          vid_hit, work_hit, echo_hit, spr_hit, hram_hit;
	hmbd_pkg::io_t io;

	assign vid_hit  = (address[15:13] == 3'b100);
	assign work_hit = (address[15:13] == 3'b110);
	// Echo stops below the sprite window
	assign echo_hit = (address[15:13] == 3'b111) && (address[12:9] != 4'hF);
	assign spr_hit  = (address[15:8] == 8'hFE) && ({1'b0, address[7:0]} < IDX_W'(SPR_BYTES));
	assign hram_hit = (address[15:7] == 9'h1FF) && (address[6:0] < 7'(HIGH_RAM_DEPTH));
	assign io       = hmbd_pkg::io_lookup(address);

	always_comb begin
		dec.big    = vid_hit | work_hit | echo_hit;
		dec.video  = vid_hit;
		dec.offset = address[hmbd_pkg::OFF_W-1:0];
		dec.hit    = dec.big | spr_hit | hram_hit | io.hit;
		dec.joypad = (address == hmbd_pkg::ADDR_JOYPAD);
		dec.div    = (address == hmbd_pkg::ADDR_DIV);
		dec.stat   = (address == hmbd_pkg::ADDR_STAT);
		// Small store layout: sprite bytes, then high RAM, then I/O registers
		priority if (spr_hit) begin
			dec.small_idx = {1'b0, address[7:0]};
		end else if (hram_hit) begin
			dec.small_idx = IDX_W'(SPR_BYTES) + {2'b00, address[6:0]};
		end else begin
			dec.small_idx = IDX_W'(SPR_BYTES + HIGH_RAM_DEPTH) + {4'b0000, io.idx};
		end
	end

endmodule

// ===== src/handheld_memory_bus_decoder.sv =====
// ----------------------------------------------------------------------------
// handheld_memory_bus_decoder
// Byte bus decoder for a handheld console map: video RAM, work RAM and its
// echo, sprite RAM, high RAM and the I/O register file.
// ----------------------------------------------------------------------------
//
// Usage:
//   Request channel: drive req and raise start; the request is taken at the
//   rising edge where start is high and busy is low. Each request reads or
//   writes one byte at a 16-bit address.
//   Result channel: done is high for exactly one cycle with rsp holding the
//   read byte and the mapped flag. The receiver cannot hold results off, so
//   no result is ever stalled or dropped.
//   Each request runs through the window modulo (reciprocal multiply, then
//   subtract), store read, modify and write back. No new request is taken
//   before the last one is through; the next request may be accepted at
//   the edge where done is high.
//   Reset: arst_n clears the control state, then a clearing pass zeroes both
//   stores, one entry per cycle, over the VIDEO_RAM_DEPTH + WORK_RAM_DEPTH
//   entries of the larger store. busy stays high during the pass.
//   Unmapped addresses give mapped = 0 and read_data = 0; writes there drop.
//
module handheld_memory_bus_decoder #(
	parameter int VIDEO_RAM_DEPTH = hmbd_pkg::VIDEO_RAM_DEPTH_DEF,
	parameter int WORK_RAM_DEPTH  = hmbd_pkg::WORK_RAM_DEPTH_DEF,
	parameter int SPRITE_ENTRIES  = hmbd_pkg::SPRITE_ENTRIES_DEF,
	parameter int HIGH_RAM_DEPTH  = hmbd_pkg::HIGH_RAM_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  hmbd_pkg::req_t req,
	output logic           done,
	output hmbd_pkg::rsp_t rsp
);

	localparam int OFF_W       = hmbd_pkg::OFF_W;
	localparam int SHIFT       = hmbd_pkg::RECIP_SHIFT;
	// Big store: video RAM first, work RAM after it
	localparam int BIG_DEPTH   = VIDEO_RAM_DEPTH + WORK_RAM_DEPTH;
	localparam int BIG_AW      = $clog2(BIG_DEPTH);
	// Small store: sprite bytes, high RAM, I/O registers
	localparam int SMALL_DEPTH = 4 * SPRITE_ENTRIES + HIGH_RAM_DEPTH + hmbd_pkg::IO_COUNT;
	localparam int SMALL_AW    = $clog2(SMALL_DEPTH);
	// Floor reciprocals for the window modulo
	localparam int RECIP_VID   = (1 << SHIFT) / VIDEO_RAM_DEPTH;
	localparam int RECIP_WRK   = (1 << SHIFT) / WORK_RAM_DEPTH;
	localparam int RECIP_MAX   = (RECIP_VID > RECIP_WRK) ? RECIP_VID : RECIP_WRK;
	localparam int RECIP_W     = $clog2(RECIP_MAX + 1);
	localparam int PROD_W      = (OFF_W + RECIP_W > SHIFT + 1) ? OFF_W + RECIP_W : SHIFT + 1;
	localparam int Q_W         = PROD_W - SHIFT;
	localparam int DEP_MAX     = (VIDEO_RAM_DEPTH > WORK_RAM_DEPTH) ?
		VIDEO_RAM_DEPTH : WORK_RAM_DEPTH;
	localparam int DEP_W       = $clog2(DEP_MAX + 1);
	localparam int R_W         = (DEP_W + 1 > OFF_W) ? DEP_W + 1 : OFF_W;

	// Sequencer codes
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_CALC  = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_RESP  = 3'd4;

	logic [2:0]        state_q;
	logic [BIG_AW-1:0] clr_q;
	logic              accept;

	hmbd_pkg::dec_t    dec;
	hmbd_pkg::req_t    req_q;
	hmbd_pkg::dec_t    dec_q;
	logic [PROD_W-1:0] prod_s1;
	logic [R_W-1:0]    rem_s2;
	logic [BIG_AW-1:0] big_idx_q;

	logic [RECIP_W-1:0] recip;
	logic [Q_W-1:0]     quo;
	logic [R_W-1:0]     dsel;
	logic [R_W-1:0]     qd;
	logic [R_W-1:0]     rem_raw;
	logic [R_W-1:0]     rem_fix;
	logic [BIG_AW-1:0]  big_idx;

	logic [7:0] big_mem   [BIG_DEPTH];
	logic [7:0] small_mem [SMALL_DEPTH];
	logic [7:0] big_rd_q, small_rd_q;

	logic                big_we, small_we, big_re, small_re;
	logic [BIG_AW-1:0]   big_waddr;
	logic [SMALL_AW-1:0] small_idx, small_waddr;
	logic [7:0]          big_wdata, small_wdata;
	logic                clearing, wr_hit;
	logic [7:0]          old_byte, new_small;

	hmbd_decode #(
		.SPRITE_ENTRIES (SPRITE_ENTRIES),
		.HIGH_RAM_DEPTH (HIGH_RAM_DEPTH)
	) u_decode (
		.address (req.address),
		.dec     (dec)
	);

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Sequencer and clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BIG_AW'(BIG_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: state_q <= ST_READ;
				ST_READ: state_q <= ST_RESP;
				ST_RESP: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Capture the request and start the window modulo with a reciprocal multiply
	assign recip = dec.video ? RECIP_W'(RECIP_VID) : RECIP_W'(RECIP_WRK);

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= req;
			dec_q   <= dec;
			prod_s1 <= PROD_W'(dec.offset) * PROD_W'(recip);
		end
	end

	// Take the quotient estimate off and subtract; it is low by at most one
	assign quo     = prod_s1[PROD_W-1:SHIFT];
	assign dsel    = dec_q.video ? R_W'(VIDEO_RAM_DEPTH) : R_W'(WORK_RAM_DEPTH);
	assign qd      = R_W'(quo) * dsel;
	assign rem_raw = R_W'(dec_q.offset) - qd;

	always_ff @(posedge clk) begin
		if (state_q == ST_CALC) begin
			rem_s2 <= rem_raw;
		end
	end

	// Correct once, then place work RAM after video RAM
	assign rem_fix = (rem_s2 >= dsel) ? rem_s2 - dsel : rem_s2;
	assign big_idx = dec_q.video ? BIG_AW'(rem_fix) :
		BIG_AW'(rem_fix) + BIG_AW'(VIDEO_RAM_DEPTH);

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			big_idx_q <= big_idx;
		end
	end

	assign small_idx = dec_q.small_idx[SMALL_AW-1:0];

	// Read-modify-write control
	assign clearing = (state_q == ST_CLEAR);
	assign wr_hit   = (state_q == ST_RESP) && dec_q.hit && (req_q.command == hmbd_pkg::CMD_WRITE);
	assign big_re   = (state_q == ST_READ) && dec_q.big;
	assign small_re = (state_q == ST_READ) && !dec_q.big;
	assign old_byte = dec_q.big ? big_rd_q : small_rd_q;

	always_comb begin
		priority if (dec_q.div) begin
			new_small = hmbd_pkg::DIV_CLEAR;
		end else if (dec_q.stat) begin
			// Keep the read-only low bits, merge the writable ones
			new_small = (small_rd_q & ~hmbd_pkg::STAT_WMASK) |
				(req_q.write_data & hmbd_pkg::STAT_WMASK);
		end else begin
			new_small = req_q.write_data;
		end
	end

	assign big_we      = clearing || (wr_hit && dec_q.big);
	assign big_waddr   = clearing ? clr_q : big_idx_q;
	assign big_wdata   = clearing ? 8'h00 : req_q.write_data;
	assign small_we    = (clearing && (clr_q < BIG_AW'(SMALL_DEPTH))) || (wr_hit && !dec_q.big);
	assign small_waddr = clearing ? clr_q[SMALL_AW-1:0] : small_idx;
	assign small_wdata = clearing ? 8'h00 : new_small;

	// Video / work RAM store
	always_ff @(posedge clk) begin
		if (big_we) begin
			big_mem[big_waddr] <= big_wdata;
		end
		if (big_re) begin
			big_rd_q <= big_mem[big_idx];
		end
	end

	// Sprite, high RAM and I/O register store
	always_ff @(posedge clk) begin
		if (small_we) begin
			small_mem[small_waddr] <= small_wdata;
		end
		if (small_re) begin
			small_rd_q <= small_mem[small_idx];
		end
	end

	// Result register: hold for one cycle, then drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= (state_q == ST_RESP);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP) begin
			rsp.mapped <= dec_q.hit;
			if (!dec_q.hit || req_q.command == hmbd_pkg::CMD_WRITE) begin
				rsp.read_data <= 8'h00;
			end else if (dec_q.joypad) begin
				rsp.read_data <= req_q.joypad_lines;
			end else begin
				rsp.read_data <= old_byte;
			end
		end
	end

	// Checks
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("accepted request did not return a result in four cycles");

	a_unmapped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.mapped) |-> (rsp.read_data == 8'h00))
		else $error("unmapped access returned nonzero data");

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> busy)
		else $error("request window open during clearing pass");

endmodule

// ===== verif/handheld_memory_bus_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// handheld_memory_bus_decoder_tb
// Self-checking bench for the memory bus decoder. It tracks every store of
// the address map in a shadow copy, predicts the read byte and the mapped
// flag of each request and compares them with each done strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module handheld_memory_bus_decoder_tb;

	// Address map of the default configuration
	localparam logic [15:0] VRAM_LO   = 16'h8000;
	localparam logic [15:0] VRAM_HI   = 16'h9FFF;
	localparam logic [15:0] WRAM_LO   = 16'hC000;
	localparam logic [15:0] WRAM_HI   = 16'hDFFF;
	localparam logic [15:0] ECHO_LO   = 16'hE000;
	localparam logic [15:0] ECHO_HI   = 16'hFDFF;
	localparam logic [15:0] OAM_LO    = 16'hFE00;
	localparam logic [15:0] HRAM_LO   = 16'hFF80;
	localparam int          OAM_BYTES = 4 * hmbd_pkg::SPRITE_ENTRIES_DEF;
	localparam int          IO_COUNT  = hmbd_pkg::IO_COUNT;

	// I/O register addresses in register file order
	localparam logic [15:0] IO_MAP [IO_COUNT] = '{
		hmbd_pkg::ADDR_JOYPAD, 16'hFF01, 16'hFF02, hmbd_pkg::ADDR_DIV, 16'hFF05,
		16'hFF06, 16'hFF07, 16'hFF0F, 16'hFF40, hmbd_pkg::ADDR_STAT, 16'hFF42,
		16'hFF43, 16'hFF44, 16'hFF45, hmbd_pkg::ADDR_DMA, 16'hFF47, 16'hFF48,
		16'hFF49, 16'hFF4A, 16'hFF4B, hmbd_pkg::ADDR_IE
	};

	localparam int RANDOM_PER_PHASE = 600;
	localparam int DRAIN_CYCLES     = 8;
	localparam int MAX_GAP          = 20;

	typedef enum int {
		STORE_NONE,
		STORE_VIDEO,
		STORE_WORK,
		STORE_SPRITE,
		STORE_HIGH,
		STORE_IO
	} store_e;

	// ------------------------------------------------------------------------
	// Shadow of the address map plus the queue of predicted responses
	// ------------------------------------------------------------------------
	class access_checker;
		bit [7:0] video_mem [hmbd_pkg::VIDEO_RAM_DEPTH_DEF];
		bit [7:0] work_mem [hmbd_pkg::WORK_RAM_DEPTH_DEF];
		bit [7:0] sprite_mem [OAM_BYTES];
		bit [7:0] high_mem [hmbd_pkg::HIGH_RAM_DEPTH_DEF];
		bit [7:0] io_regs [IO_COUNT];
		hmbd_pkg::rsp_t pending_rsp [$];
		int       failures;

		// Resolve an address to a store and an index within it
		function void map_address(input logic [15:0] a, output store_e s,
				output int unsigned idx);
			s = STORE_NONE;
			idx = 0;
			if (a >= VRAM_LO && a <= VRAM_HI) begin
				s = STORE_VIDEO;
				idx = (a - VRAM_LO) % hmbd_pkg::VIDEO_RAM_DEPTH_DEF;
			end else if (a >= WRAM_LO && a <= WRAM_HI) begin
				s = STORE_WORK;
				idx = (a - WRAM_LO) % hmbd_pkg::WORK_RAM_DEPTH_DEF;
			end else if (a >= ECHO_LO && a <= ECHO_HI) begin
				s = STORE_WORK;
				idx = (a - ECHO_LO) % hmbd_pkg::WORK_RAM_DEPTH_DEF;
			end else if (a >= OAM_LO && int'(a) < int'(OAM_LO) + OAM_BYTES) begin
				s = STORE_SPRITE;
				idx = a - OAM_LO;
			end else if (a >= HRAM_LO &&
					int'(a) < int'(HRAM_LO) + hmbd_pkg::HIGH_RAM_DEPTH_DEF) begin
				s = STORE_HIGH;
				idx = a - HRAM_LO;
			end else begin
				for (int i = 0; i < IO_COUNT; i++)
					if (IO_MAP[i] == a) begin
						s = STORE_IO;
						idx = i;
					end
			end
		endfunction

		function bit [7:0] peek(store_e s, int unsigned idx);
			unique case (s)
				STORE_VIDEO:  return video_mem[idx];
				STORE_WORK:   return work_mem[idx];
				STORE_SPRITE: return sprite_mem[idx];
				STORE_HIGH:   return high_mem[idx];
				STORE_IO:     return io_regs[idx];
				default:      return 8'h00;
			endcase
		endfunction

		function void poke(store_e s, int unsigned idx, bit [7:0] v);
			unique case (s)
				STORE_VIDEO:  video_mem[idx] = v;
				STORE_WORK:   work_mem[idx] = v;
				STORE_SPRITE: sprite_mem[idx] = v;
				STORE_HIGH:   high_mem[idx] = v;
				STORE_IO:     io_regs[idx] = v;
				default:      ;
			endcase
		endfunction

		// Apply an accepted request to the shadow and queue its response
		function void note_request(hmbd_pkg::req_t r);
			store_e         s;
			int unsigned    idx;
			bit [7:0]       cur;
			hmbd_pkg::rsp_t p;
			map_address(r.address, s, idx);
			p.mapped = (s != STORE_NONE);
			p.read_data = 8'h00;
			if (s != STORE_NONE) begin
				cur = peek(s, idx);
				if (r.command == hmbd_pkg::CMD_WRITE) begin
					if (r.address == hmbd_pkg::ADDR_DIV)
						poke(s, idx, hmbd_pkg::DIV_CLEAR);
					else if (r.address == hmbd_pkg::ADDR_STAT)
						poke(s, idx, (cur & ~hmbd_pkg::STAT_WMASK) |
							(r.write_data & hmbd_pkg::STAT_WMASK));
					else
						poke(s, idx, r.write_data);
				end else begin
					p.read_data = (r.address == hmbd_pkg::ADDR_JOYPAD) ?
						r.joypad_lines : cur;
				end
			end
			pending_rsp.push_back(p);
		endfunction

		function void check_result(hmbd_pkg::rsp_t r);
			hmbd_pkg::rsp_t p;
			if (pending_rsp.size() == 0) begin
				$error("response with no request outstanding: read_data %0h mapped %0b",
					r.read_data, r.mapped);
				failures++;
				return;
			end
			p = pending_rsp.pop_front();
			if (r.read_data !== p.read_data) begin
				$error("read_data: expected %0h, actual %0h", p.read_data, r.read_data);
				failures++;
			end
			if (r.mapped !== p.mapped) begin
				$error("mapped: expected %0b, actual %0b", p.mapped, r.mapped);
				failures++;
			end
		endfunction

		function int outstanding();
			return pending_rsp.size();
		endfunction

		function void flag_leftovers();
			if (pending_rsp.size() != 0) begin
				$error("%0d responses never arrived", pending_rsp.size());
				failures++;
			end
		endfunction
	endclass

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	hmbd_pkg::req_t req;
	logic           done;
	hmbd_pkg::rsp_t rsp;

	access_checker checker_h;

	handheld_memory_bus_decoder DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watch both channels on every edge. Inputs change by nonblocking
	// assignment, so start and req seen here are the values at the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				checker_h.note_request(req);
			if (done)
				checker_h.check_result(rsp);
		end
	end

	// Hold the request until the block takes it, then idle for the given gap
	task automatic issue(input hmbd_pkg::req_t r, input int unsigned gap);
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop start and hold until every response has come back; the first edge
	// lets the monitor log the request taken at the current edge
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (checker_h.outstanding() != 0)
			@(posedge clk);
	endtask

	task automatic access(input logic cmd, input logic [15:0] a, input logic [7:0] wd,
			input logic [7:0] joy);
		hmbd_pkg::req_t r;
		r.command = cmd;
		r.address = a;
		r.write_data = wd;
		r.joypad_lines = joy;
		issue(r, 0);
	endtask

	// Idle each following cycle with the given chance, up to a bound
	function automatic int unsigned pick_gap(int unsigned idle_pct);
		int unsigned gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
			gap++;
		return gap;
	endfunction

	// Bias addresses toward small offsets so reads often land on written bytes
	function automatic logic [15:0] pick_address();
		case ($urandom_range(9))
			0, 1: return 16'(VRAM_LO + (($urandom_range(3) == 0) ?
				$urandom_range(16'h1FFF) : $urandom_range(31)));
			2:    return 16'(WRAM_LO + (($urandom_range(3) == 0) ?
				$urandom_range(16'h1FFF) : $urandom_range(31)));
			3:    return 16'(ECHO_LO + (($urandom_range(3) == 0) ?
				$urandom_range(16'h1DFF) : $urandom_range(31)));
			4:    return 16'(OAM_LO + $urandom_range(8'hBF));
			5:    return 16'(HRAM_LO + $urandom_range(8'h7F));
			6, 7: return IO_MAP[$urandom_range(IO_COUNT - 1)];
			8:    return 16'(16'hFF00 + $urandom_range(8'h7F));
			default: return 16'($urandom_range(16'hFFFF));
		endcase
	endfunction

	task automatic random_phase(input int unsigned idle_pct);
		hmbd_pkg::req_t r;
		for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
			r.command = ($urandom_range(1) == 1) ? hmbd_pkg::CMD_WRITE : hmbd_pkg::CMD_READ;
			r.address = pick_address();
			r.write_data = 8'($urandom_range(8'hFF));
			r.joypad_lines = 8'($urandom_range(8'hFF));
			issue(r, pick_gap(idle_pct));
		end
	endtask

	initial begin
		checker_h = new();
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: window edges, echo aliasing, special registers, unmapped holes
		access(hmbd_pkg::CMD_READ,  VRAM_LO,               8'h00, 8'h00);
		access(hmbd_pkg::CMD_WRITE, VRAM_LO,               8'hFF, 8'h00);
		access(hmbd_pkg::CMD_WRITE, VRAM_HI,               8'hA5, 8'hFF);
		access(hmbd_pkg::CMD_READ,  VRAM_HI,               8'h00, 8'h00);
		access(hmbd_pkg::CMD_WRITE, WRAM_LO,               8'h5A, 8'h00);
		access(hmbd_pkg::CMD_READ,  ECHO_LO,               8'h00, 8'h00);
		access(hmbd_pkg::CMD_WRITE, ECHO_HI,               8'h3C, 8'h00);
		access(hmbd_pkg::CMD_READ,  16'hDDFF,              8'h00, 8'h00);
		access(hmbd_pkg::CMD_WRITE, WRAM_HI,               8'h81, 8'h00);
		access(hmbd_pkg::CMD_READ,  WRAM_HI,               8'h00, 8'h00);
		access(hmbd_pkg::CMD_WRITE, 16'hFE9F,              8'h77, 8'h00);
		access(hmbd_pkg::CMD_READ,  16'hFE9F,              8'h00, 8'h00);
		access(hmbd_pkg::CMD_READ,  16'hFEA0,              8'h00, 8'h00);
		access(hmbd_pkg::CMD_WRITE, 16'hFFFE,              8'hC3, 8'h00);
		access(hmbd_pkg::CMD_READ,  16'hFFFE,              8'h00, 8'h00);
		access(hmbd_pkg::CMD_WRITE, hmbd_pkg::ADDR_JOYPAD, 8'h12, 8'h00);
		access(hmbd_pkg::CMD_READ,  hmbd_pkg::ADDR_JOYPAD, 8'h00, 8'hE7);
		access(hmbd_pkg::CMD_WRITE, hmbd_pkg::ADDR_DIV,    8'hFF, 8'h00);
		access(hmbd_pkg::CMD_READ,  hmbd_pkg::ADDR_DIV,    8'h00, 8'h00);
		access(hmbd_pkg::CMD_WRITE, hmbd_pkg::ADDR_STAT,   8'hFF, 8'h00);
		access(hmbd_pkg::CMD_READ,  hmbd_pkg::ADDR_STAT,   8'h00, 8'h00);
		access(hmbd_pkg::CMD_WRITE, hmbd_pkg::ADDR_IE,     8'h1F, 8'h00);
		access(hmbd_pkg::CMD_READ,  hmbd_pkg::ADDR_IE,     8'h00, 8'h00);
		access(hmbd_pkg::CMD_WRITE, 16'hA000,              8'hEE, 8'h00);
		access(hmbd_pkg::CMD_READ,  16'hFF03,              8'h00, 8'hFF);
		drain();

		// Random traffic: sender idles 29 %, then 68 %, then never
		random_phase(29);
		drain();
		random_phase(68);
		drain();
		random_phase(0);
		drain();

		repeat (DRAIN_CYCLES) @(posedge clk);
		checker_h.flag_leftovers();
		if (checker_h.failures == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Clearing pass after reset plus all requests fit many times in this window
	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== handheld_memory_bus_decoder.f =====
src/hmbd_pkg.sv
src/hmbd_decode.sv
src/handheld_memory_bus_decoder.sv
verif/handheld_memory_bus_decoder_tb.sv
